FILE: hdl/edb_pkg.sv
// shared types, reset values and arithmetic helpers for the error diffusion binarizer
`default_nettype none

package edb_pkg;

    // grey level and signed diffusion error
    typedef logic [7:0]        pix_t;
    typedef logic signed [8:0] err_t;

    // neighbourhood of the pixel being judged
    typedef struct packed {
        logic first_row;
        logic left_edge;
        logic right_ok;
        err_t err_ul;
        err_t err_up;
        err_t err_ur;
        err_t err_left;
    } nbr_t;

    // configuration reset values
    localparam logic [7:0]  THRESHOLD_RESET  = 8'd150;
    localparam logic [10:0] LINE_WIDTH_RESET = 11'd640;

    // register selects, decoded on paddr[2]
    localparam logic REG_THRESHOLD  = 1'b0;
    localparam logic REG_LINE_WIDTH = 1'b1;

    // diffusion weights in sixteenths
    localparam logic [3:0] W_UL   = 4'd1;
    localparam logic [3:0] W_UP   = 4'd5;
    localparam logic [3:0] W_UR   = 4'd3;
    localparam logic [3:0] W_LEFT = 4'd7;

    // floor(err * k / 16), arithmetic shift rounds toward minus infinity
    function automatic err_t share(input err_t err, input logic [3:0] k);
        logic signed [12:0] p;
        p = $signed({{4{err[8]}}, err}) * $signed({9'd0, k});
        return p[12:4];
    endfunction

    // add a signed share and saturate to 0..255
    function automatic pix_t add_clamp(input pix_t v, input err_t d);
        logic signed [9:0] s;
        s = $signed({2'b00, v}) + $signed({d[8], d});
        if (s < 0) begin
            return 8'd0;
        end else if (s > 10'sd255) begin
            return 8'd255;
        end
        return s[7:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/edb_ram.sv
// generic single write port ram with registered read
`default_nettype none

module edb_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/edb_diffuse.sv
// neighbour error accumulation, threshold decision and new pixel error
`default_nettype none

module edb_diffuse (
    input  wire edb_pkg::pix_t pixel,
    input  wire edb_pkg::nbr_t nbr,
    input  wire logic [7:0]    threshold,
    output logic               white,
    output edb_pkg::err_t      err
);
    import edb_pkg::*;

    pix_t v_ul, v_up, v_ur, v_left;

    // shares added in order: upper-left, upper, upper-right, left
    always_comb begin
        v_ul   = (!nbr.first_row && !nbr.left_edge) ?
                 add_clamp(pixel, share(nbr.err_ul, W_UL)) : pixel;
        v_up   = !nbr.first_row ? add_clamp(v_ul, share(nbr.err_up, W_UP)) : v_ul;
        v_ur   = (!nbr.first_row && nbr.right_ok) ?
                 add_clamp(v_up, share(nbr.err_ur, W_UR)) : v_up;
        v_left = !nbr.left_edge ? add_clamp(v_ur, share(nbr.err_left, W_LEFT)) : v_ur;
    end

    // decision and residual error
    always_comb begin
        white = v_left > threshold;
        err   = white ? ($signed({1'b0, v_left}) - 9'sd255) : $signed({1'b0, v_left});
    end

endmodule

`default_nettype wire

FILE: hdl/error_diffusion_binarizer.sv
// top level of the floyd-steinberg error diffusion binarizer
//
//  channel   direction  handshake                 payload
//  s_        in         s_tvalid / s_tready       s_tdata pixel_value, s_tuser frame_start
//  m_        out        m_tvalid / m_tready       m_tdata pixel_white
//  apb       in         psel / penable / pready   threshold at 0x0, line_width at 0x4
//
//  one pixel per clock sustained while m_tready stays high; the left-error feedback closes through left_reg
//  two registers on the path: input register, then result register
//  the previous row's errors sit in a MAX_WIDTH-entry ram read one pixel ahead
//  aresetn is synchronous; the error ram is not cleared and needs no clearing pass
//  a stalled result holds, while one more pixel may still be taken into the input register
`default_nettype none

module error_diffusion_binarizer #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // pixel input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] pixel_value
    input  wire logic        s_tuser,   // [0] frame_start
    // binary output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata    // [0] pixel_white, [7:1] zero
);
    import edb_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > 11) ? CW + 1 : 11;

    // configuration registers
    logic [7:0]  threshold_reg;
    logic [10:0] line_width_reg;

    // input and result registers
    logic        in_valid_reg;
    pix_t        in_pixel_reg;
    logic        in_fs_reg;
    logic        out_valid_reg;
    logic        out_white_reg;

    // raster state
    logic [CW-1:0] col_reg;
    logic          first_reg;
    err_t          left_reg;
    err_t          tap0_reg;
    err_t          tap1_reg;
    err_t          col0_reg;
    logic          byp_hit_reg;
    err_t          byp_data_reg;

    logic          s_accept;
    logic          fire;
    logic [EW-1:0] lw_ext;
    logic [EW-1:0] act_width;
    logic [CW-1:0] x_cur;
    logic          first_e;
    err_t          left_e;
    err_t          tap0_e;
    err_t          tap1_e;
    logic          row_last;
    err_t          upright;
    err_t          ram_rdata;
    nbr_t          nbr;
    logic          white;
    err_t          err;
    logic [CW-1:0] col_next;
    logic [CW-1:0] x_acc;
    logic [CW-1:0] raddr;

    // apb register access
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= THRESHOLD_RESET;
            line_width_reg <= LINE_WIDTH_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_THRESHOLD:  threshold_reg  <= pwdata[7:0];
                REG_LINE_WIDTH: line_width_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_THRESHOLD:  prdata = 32'(threshold_reg);
            REG_LINE_WIDTH: prdata = 32'(line_width_reg);
            default:        prdata = 32'd0;
        endcase
    end

    // handshake: process when the result register is free or being drained
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_white_reg};

    // active width, zero acts as one and large values saturate
    always_comb begin
        lw_ext = EW'(line_width_reg);
        if (lw_ext == '0) begin
            act_width = EW'(1);
        end else if (lw_ext > EW'(MAX_WIDTH)) begin
            act_width = EW'(MAX_WIDTH);
        end else begin
            act_width = lw_ext;
        end
    end

    // state seen by the current pixel, frame start clears it first
    always_comb begin
        x_cur    = in_fs_reg ? '0 : col_reg;
        first_e  = in_fs_reg || first_reg;
        left_e   = in_fs_reg ? '0 : left_reg;
        tap0_e   = in_fs_reg ? '0 : tap0_reg;
        tap1_e   = in_fs_reg ? '0 : tap1_reg;
        row_last = (EW'(x_cur) + EW'(1)) >= act_width;
        upright  = byp_hit_reg ? byp_data_reg : ram_rdata;
    end

    always_comb begin
        nbr.first_row = first_e;
        nbr.left_edge = (x_cur == '0);
        nbr.right_ok  = !row_last;
        nbr.err_ul    = tap0_e;
        nbr.err_up    = tap1_e;
        nbr.err_ur    = upright;
        nbr.err_left  = left_e;
    end

    edb_diffuse u_diffuse (
        .pixel     (in_pixel_reg),
        .nbr       (nbr),
        .threshold (threshold_reg),
        .white     (white),
        .err       (err)
    );

    // read address for the pixel being taken: one column to its right
    always_comb begin
        col_next = row_last ? '0 : x_cur + CW'(1);
        if (s_tuser) begin
            x_acc = '0;
        end else if (fire) begin
            x_acc = col_next;
        end else begin
            x_acc = col_reg;
        end
        raddr = x_acc + CW'(1);
    end

    edb_ram #(
        .WIDTH ($bits(err_t)),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (fire),
        .waddr (x_cur),
        .wdata (err),
        .re    (s_accept),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // forward an error written in the same cycle as it is read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_hit_reg <= 1'b0;
        end else if (s_accept) begin
            byp_hit_reg <= fire && (x_cur == raddr);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            byp_data_reg <= err;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_pixel_reg <= s_tdata;
            in_fs_reg    <= s_tuser;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_white_reg <= white;
        end
    end

    // raster state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            first_reg <= 1'b1;
            left_reg  <= '0;
            tap0_reg  <= '0;
            tap1_reg  <= '0;
        end else if (fire) begin
            col_reg   <= col_next;
            first_reg <= row_last ? 1'b0 : first_e;
            left_reg  <= row_last ? '0 : err;
            tap0_reg  <= row_last ? '0 : tap1_e;
            if (row_last) begin
                tap1_reg <= (x_cur == '0) ? err : col0_reg;
            end else begin
                tap1_reg <= upright;
            end
        end
    end

    // copy of the column zero error for the start of the next row
    always_ff @(posedge aclk) begin
        if (fire && (x_cur == '0)) begin
            col0_reg <= err;
        end
    end

`ifndef NO_ASSERTIONS
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while a slot was free");

    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed pixel did not reach the result register");

    a_accept_fills_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> in_valid_reg)
        else $error("accepted pixel lost from the input register");

    a_row_end_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && row_last) |=> (col_reg == '0 && !first_reg && left_reg == '0))
        else $error("row end did not return to column zero");
`endif

endmodule

`default_nettype wire
